[src/abg_pkg.sv]
`timescale 1ns / 1ps

package abg_pkg;

  // field widths
  localparam int unsigned BaseW  = 11;
  localparam int unsigned RatioW = 13;
  localparam int unsigned ScaleW = 15;
  localparam int unsigned CoordW = 29;

  // internal widths
  localparam int unsigned LimW   = 33;  // 1024*b*b
  localparam int unsigned AccW   = 48;  // t*t*r
  localparam int unsigned ProdW  = 32;  // t*r
  localparam int unsigned TW     = 17;  // t = 2n
  localparam int unsigned NwW    = 16;
  localparam int unsigned NhW    = 23;
  localparam int unsigned HwW    = NwW + ScaleW;
  localparam int unsigned HhW    = NhW + ScaleW;
  localparam int unsigned SumW   = 40;

  localparam int unsigned NBits  = 16;               // width search bits
  localparam int unsigned NStg   = 2 * NBits + 1;    // search stages incl. entry

  localparam logic signed [SumW-1:0] CoordMax = SumW'(268435455);
  localparam logic signed [SumW-1:0] CoordMin = -SumW'(268435456);

  // one search stage
  typedef struct packed {
    logic [RatioW-1:0] ratio;
    logic [ScaleW-1:0] scale;
    logic [BaseW-1:0]  base;
    logic [LimW-1:0]   limit;
    logic [TW-1:0]     t;
    logic [AccW-1:0]   acc;
    logic [ProdW-1:0]  prod;
    logic [TW-1:0]     t_n;
    logic [AccW-1:0]   acc_n;
    logic [ProdW-1:0]  prod_n;
  } srch_t;

  function automatic logic [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] c;
    c = v;
    if (v > CoordMax) c = CoordMax;
    if (v < CoordMin) c = CoordMin;
    return c[CoordW-1:0];
  endfunction

endpackage

[src/anchor_box_generator_top.sv]
`timescale 1ns / 1ps
// channel | signals                                   | transfer when
// in      | in_valid_i, in_ready_o, aspect_ratio_i,   | in_valid_i & in_ready_o
//         | box_scale_i                               |
// out     | out_valid_o, out_ready_i, anchor_*_o      | out_valid_o & out_ready_i
// cfg     | cfg_we_i, cfg_wdata_i (base side)         | cfg_we_i
// one item per cycle while the output is not stalled; an entry stage, the bit-serial width search
// (two stages per result bit), then height, scale multiply and edge/saturate stages.
// reset clears all valid bits and sets the base side to 16.
// a stall at the output freezes the whole pipeline; nothing is dropped.
module anchor_box_generator_top
  import abg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BaseW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [RatioW-1:0] aspect_ratio_i,
  input  logic [ScaleW-1:0] box_scale_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] anchor_x0_o,
  output logic [CoordW-1:0] anchor_y0_o,
  output logic [CoordW-1:0] anchor_x1_o,
  output logic [CoordW-1:0] anchor_y1_o
);

  logic [BaseW-1:0] base_q;
  logic             adv;
  srch_t            ent_d;
  srch_t            st_q [NStg];
  logic             v_q  [NStg];

  // whole pipeline moves unless the output holds a result nobody takes
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // base size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseW'(16);
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_comb begin
    ent_d       = '0;
    ent_d.ratio = (aspect_ratio_i == '0) ? RatioW'(1) : aspect_ratio_i;
    ent_d.scale = box_scale_i;
    ent_d.base  = base_q;
    ent_d.limit = LimW'({base_q, 10'b0}) * LimW'(base_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= ent_d;
    end
  end

  // width search: two stages per bit, msb first
  for (genvar j = 0; j < NBits; j++) begin : g_bit
    localparam int unsigned K = NBits - 1 - j;
    srch_t            pa_d, pb_d;
    logic [AccW-1:0]  test;

    // propose t + 2^(k+1)
    always_comb begin
      pa_d        = st_q[2*j];
      pa_d.t_n    = st_q[2*j].t + TW'(1 << (K + 1));
      pa_d.acc_n  = st_q[2*j].acc + (AccW'(st_q[2*j].prod) << (K + 2))
                  + (AccW'(st_q[2*j].ratio) << (2 * K + 2));
      pa_d.prod_n = st_q[2*j].prod + (ProdW'(st_q[2*j].ratio) << (K + 1));
    end

    // keep it if (t_n - 1)^2 * r fits under the limit
    always_comb begin
      pb_d = st_q[2*j+1];
      test = st_q[2*j+1].acc_n - AccW'({st_q[2*j+1].prod_n, 1'b0})
           + AccW'(st_q[2*j+1].ratio);
      if (test <= AccW'(st_q[2*j+1].limit)) begin
        pb_d.t    = st_q[2*j+1].t_n;
        pb_d.acc  = st_q[2*j+1].acc_n;
        pb_d.prod = st_q[2*j+1].prod_n;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[2*j+1] <= 1'b0;
        v_q[2*j+2] <= 1'b0;
      end else if (adv) begin
        v_q[2*j+1] <= v_q[2*j];
        v_q[2*j+2] <= v_q[2*j+1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[2*j+1] <= pa_d;
        st_q[2*j+2] <= pb_d;
      end
    end
  end

  // height stage: new_h = (n*r + 128) >> 8 with prod = 2*n*r
  logic              hv_q;
  logic [NwW-1:0]    nw_q;
  logic [NhW-1:0]    nh_q;
  logic [ScaleW-1:0] sc_q;
  logic [BaseW-1:0]  bh_q;
  logic [ProdW:0]    hsum;

  assign hsum = {1'b0, st_q[NStg-1].prod} + (ProdW+1)'(256);

  // multiply stage
  logic              mv_q;
  logic [HwW-1:0]    hw_q;
  logic [HhW-1:0]    hh_q;
  logic [BaseW-1:0]  bm_q;

  // output stage
  logic signed [SumW-1:0] c2, hws, hhs;

  assign c2  = SumW'({bm_q, 8'b0});
  assign hws = SumW'(hw_q);
  assign hhs = SumW'(hh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q        <= 1'b0;
      mv_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      hv_q        <= v_q[NStg-1];
      mv_q        <= hv_q;
      out_valid_o <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nw_q        <= st_q[NStg-1].t[TW-1:1];
      nh_q        <= hsum[NhW+8:9];
      sc_q        <= st_q[NStg-1].scale;
      bh_q        <= st_q[NStg-1].base;
      hw_q        <= HwW'(nw_q) * HwW'(sc_q);
      hh_q        <= HhW'(nh_q) * HhW'(sc_q);
      bm_q        <= bh_q;
      anchor_x0_o <= sat_coord(c2 - hws);
      anchor_y0_o <= sat_coord(c2 - hhs);
      anchor_x1_o <= sat_coord(c2 - SumW'(512) + hws);
      anchor_y1_o <= sat_coord(c2 - SumW'(512) + hhs);
    end
  end

endmodule

[src/abg_checker.sv]
`timescale 1ns / 1ps
module abg_checker
  import abg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CoordW-1:0] anchor_x0_o,
  input logic [CoordW-1:0] anchor_x1_o,
  input logic [CoordW-1:0] anchor_y0_o,
  input logic [CoordW-1:0] anchor_y1_o
);

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped under stall");

  // stalled result keeps its x0 and y1 edges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(anchor_x0_o) && $stable(anchor_y1_o))
    else $error("result changed under stall");

  // input side is only held off while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output stall");

  // right edge never lies more than one pixel left of the left edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed({anchor_x1_o[CoordW-1], anchor_x1_o}) + 30'sd512
                     >= $signed({anchor_x0_o[CoordW-1], anchor_x0_o})))
    else $error("x edges out of order");

endmodule

bind anchor_box_generator_top abg_checker u_abg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .anchor_x0_o (anchor_x0_o),
  .anchor_x1_o (anchor_x1_o),
  .anchor_y0_o (anchor_y0_o),
  .anchor_y1_o (anchor_y1_o)
);

[sim/anchor_box_checker.sv]
`timescale 1ns / 1ps
module anchor_box_checker
  import abg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BaseW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  logic [RatioW-1:0] aspect_ratio_i,
  input  logic [ScaleW-1:0] box_scale_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [CoordW-1:0] anchor_x0_o,
  input  logic [CoordW-1:0] anchor_y0_o,
  input  logic [CoordW-1:0] anchor_x1_o,
  input  logic [CoordW-1:0] anchor_y1_o,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
  } box_t;

  logic [BaseW-1:0] base_q;
  box_t             box_q[$];

  // clamp to the coordinate range and keep 29 bits
  function automatic logic [CoordW-1:0] clamp_coord(input longint v);
    longint c;
    c = v;
    if (c > 64'sd268435455) c = 64'sd268435455;
    if (c < -64'sd268435456) c = -64'sd268435456;
    return c[CoordW-1:0];
  endfunction

  // anchor edges for one ratio/scale pair
  function automatic box_t anchor_of(input logic [BaseW-1:0] b_in,
                                     input logic [RatioW-1:0] r_in,
                                     input logic [ScaleW-1:0] s_in);
    longint unsigned b, r, s, lim, nw, nh, cand, odd;
    longint cen;
    box_t bx;
    b = b_in;
    r = (r_in == 0) ? 1 : r_in;
    s = s_in;
    lim = 1024 * b * b;
    nw = 0;
    // largest n with (2n-1)^2 * r <= limit
    for (int k = 15; k >= 0; k--) begin
      cand = nw | (64'd1 << k);
      odd = 2 * cand - 1;
      if (odd * odd * r <= lim) nw = cand;
    end
    nh = (nw * r + 128) >> 8;
    cen = longint'(256 * b);
    bx.x0 = clamp_coord(cen - longint'(nw * s));
    bx.y0 = clamp_coord(cen - longint'(nh * s));
    bx.x1 = clamp_coord(cen - 512 + longint'(nw * s));
    bx.y1 = clamp_coord(cen - 512 + longint'(nh * s));
    return bx;
  endfunction

  assign pending_o = box_q.size();

  // track config, predict on input transfer, compare on output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    box_t exp_b, got_b;
    if (!rst_ni) begin
      base_q <= 11'd16;
      fail_count_o <= 0;
      box_q.delete();
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_o)
        box_q.push_back(anchor_of(base_q, aspect_ratio_i, box_scale_i));
      if (out_valid_o && out_ready_i) begin
        got_b = '{anchor_x0_o, anchor_y0_o, anchor_x1_o, anchor_y1_o};
        if (box_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected output transfer %h", got_b);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_b = box_q.pop_front();
          if (exp_b !== got_b) begin
            if (fail_count_o < 10)
              $display("mismatch: exp x0 %h y0 %h x1 %h y1 %h, got x0 %h y0 %h x1 %h y1 %h",
                       exp_b.x0, exp_b.y0, exp_b.x1, exp_b.y1,
                       got_b.x0, got_b.y0, got_b.x1, got_b.y1);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[sim/anchor_box_generator_top_test.sv]
`timescale 1ns / 1ps
module anchor_box_generator_top_test;
  import abg_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [BaseW-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [RatioW-1:0] aspect_ratio_i = '0;
  logic [ScaleW-1:0] box_scale_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CoordW-1:0] anchor_x0_o, anchor_y0_o, anchor_x1_o, anchor_y1_o;
  int                fail_count, pending;
  int                cycle_cnt = 0;
  bit                calm = 1'b0;

  anchor_box_generator_top u_dut (.*);

  anchor_box_checker u_chk (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("anchor_box_generator_top test failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      if (!calm) repeat ($urandom_range(0, 15)) @(posedge clk_i);
    end
  end

  // one transfer, with an optional idle burst first
  task automatic send_pair(input logic [RatioW-1:0] r, input logic [ScaleW-1:0] s);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    aspect_ratio_i <= r;
    box_scale_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drain then write the base side
  task automatic set_base(input logic [BaseW-1:0] b);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random pair, mostly in range
  task automatic send_random();
    logic [RatioW-1:0] r;
    logic [ScaleW-1:0] s;
    r = ($urandom_range(0, 9) == 0) ? RatioW'($urandom) : RatioW'($urandom_range(16, 4096));
    s = ($urandom_range(0, 9) == 0) ? ScaleW'($urandom) : ScaleW'($urandom_range(16, 16384));
    send_pair(r, s);
  endtask

  initial begin
    logic [BaseW-1:0] bases[6];
    bases = '{11'd1, 11'd1024, 11'd0, 11'h7FF, 11'd37, 11'd16};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset base size, field extremes and special ratios
    send_pair(13'd256, 15'd256);
    send_pair(13'd0, 15'd256);
    send_pair(13'd1, 15'h7FFF);
    send_pair(13'h1FFF, 15'd0);
    send_pair(13'd16, 15'd16);
    send_pair(13'd4096, 15'd16384);
    send_pair(13'd128, 15'd512);
    send_pair(13'd512, 15'd8192);
    send_pair(13'h1555, 15'h2AAA);
    send_pair(13'h0AAA, 15'h5555);
    // phases over several base sizes, extremes included
    foreach (bases[i]) begin
      set_base(bases[i]);
      send_pair(13'd0, 15'h7FFF);
      send_pair(13'h1FFF, 15'h7FFF);
      repeat (105) send_random();
    end
    // last stretch with no idling
    calm = 1'b1;
    repeat (60) send_random();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("anchor_box_generator_top test passed");
    end else begin
      $display("anchor_box_generator_top test failed");
    end
    $finish;
  end

endmodule
